/* src/sru_pkg.sv */
// shared types and constants for the sort-and-dedup block
`default_nettype none
package sru_pkg;

    localparam int VALUE_W = 32;

    // one slot of data moving through or held in the cell chain
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
    } t_token;

    // control broadcast to every cell
    typedef struct packed {
        logic shift;  // unload: every cell takes its right neighbor's value
    } t_cell_ctl;

endpackage
`default_nettype wire

/* src/sru_if.sv */
// handshake interfaces for the input and result channels
`default_nettype none
interface sru_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        batch_end;

    modport source (output valid, output value, output batch_end, input ready);
    modport sink (input valid, input value, input batch_end, output ready);
endinterface

interface sru_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] unique_value;
    logic        final_result;
    logic        overflow;

    modport source (output valid, output unique_value, output final_result,
                    output overflow, input ready);
    modport sink (input valid, input unique_value, input final_result,
                  input overflow, output ready);
endinterface
`default_nettype wire

/* src/sru_cell.sv */
// one cell of the systolic insertion sorter with duplicate removal
`default_nettype none
module sru_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  sru_pkg::t_cell_ctl  i_ctl,
    input  sru_pkg::t_token     i_in,
    input  sru_pkg::t_token     i_right,
    output sru_pkg::t_token     o_pass,
    output sru_pkg::t_token     o_held
);

    sru_pkg::t_token r_held;
    sru_pkg::t_token n_held;
    sru_pkg::t_token r_pass;
    sru_pkg::t_token n_pass;

    always_comb begin
        n_held       = r_held;
        n_pass       = '0;
        n_pass.valid = 1'b0;
        if (i_ctl.shift) begin
            n_held = i_right;
        end else if (i_in.valid) begin
            if (!r_held.valid) begin
                n_held = i_in;
            end else if (i_in.value < r_held.value) begin
                // keep the smaller, push the larger right
                n_held = i_in;
                n_pass = r_held;
            end else if (i_in.value != r_held.value) begin
                n_pass = i_in;
            end
            // equal value: duplicate, dropped here
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held.valid <= 1'b0;
            r_pass.valid <= 1'b0;
        end else begin
            r_held.valid <= n_held.valid;
            r_pass.valid <= n_pass.valid;
        end
        r_held.value <= n_held.value;
        r_pass.value <= n_pass.value;
    end

    assign o_pass = r_pass;
    assign o_held = r_held;

endmodule
`default_nettype wire

/* src/sort_and_remove_duplicates.sv */
// top level: batch sorter that emits distinct values in ascending order
//
// channel  | dir | payload                                   | accepted when
// ---------+-----+-------------------------------------------+------------------------
// i_in     | in  | value[31:0] signed, batch_end             | i_in.valid & i_in.ready
// o_out    | out | unique_value[31:0], final_result, overflow | o_out.valid & o_out.ready
//
// load: one item per cycle while i_in.ready is high; values ripple one cell per cycle down the chain
// after the batch_end item, the chain settles in ST_DRAIN for a time set by the chain length
// unload: one result per cycle from cell 0 while o_out.ready is high; the chain
// shifts left on each accepted result, so a stall simply holds cell 0
// i_in.ready is low from batch_end until the last result is taken
// reset (synchronous, active low) empties every cell and returns to loading
`default_nettype none
module sort_and_remove_duplicates #(
    parameter int MAX_ITEMS = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sru_in_if.sink     i_in,
    sru_out_if.source  o_out
);

    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int DRAIN_W = $clog2(MAX_ITEMS);

    // state codes
    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_drop;
    logic               n_drop;
    logic [DRAIN_W-1:0] r_drain;
    logic [DRAIN_W-1:0] n_drain;

    logic in_fire;
    logic out_fire;
    logic full;

    sru_pkg::t_token   head;
    sru_pkg::t_token   none_tok;
    sru_pkg::t_cell_ctl ctl;
    sru_pkg::t_token   held [MAX_ITEMS];
    sru_pkg::t_token   pass [MAX_ITEMS];

    assign i_in.ready = (r_state == ST_LOAD);
    assign in_fire    = i_in.valid & i_in.ready;
    assign out_fire   = o_out.valid & o_out.ready;
    assign full       = (r_count == CNT_W'(MAX_ITEMS));

    // item entering the chain; dropped once the batch is at capacity
    always_comb begin
        head.valid = in_fire & ~full;
        head.value = $signed(i_in.value);
        none_tok   = '0;
        ctl.shift  = out_fire;
    end

    // the chain: each cell keeps the smaller value and hands the larger one to the right
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        sru_pkg::t_token cin;
        sru_pkg::t_token cright;
        if (g == 0) begin : g_first
            assign cin = head;
        end else begin : g_mid
            assign cin = pass[g-1];
        end
        if (g == MAX_ITEMS - 1) begin : g_last
            assign cright = none_tok;
        end else begin : g_notlast
            assign cright = held[g+1];
        end
        sru_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_in    (cin),
            .i_right (cright),
            .o_pass  (pass[g]),
            .o_held  (held[g])
        );
    end

    // results stream straight out of cell 0
    assign o_out.valid        = (r_state == ST_EMIT) & held[0].valid;
    assign o_out.unique_value = held[0].value;
    assign o_out.final_result = ~held[1].valid;
    assign o_out.overflow     = r_drop;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        n_drain = r_drain;
        case (r_state)
            ST_LOAD: begin
                if (in_fire) begin
                    if (full) begin
                        n_drop = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_in.batch_end) begin
                        n_state = ST_DRAIN;
                        n_drain = '0;
                    end
                end
            end
            ST_DRAIN: begin
                // let the last item settle into its cell
                n_drain = r_drain + DRAIN_W'(1);
                if (r_drain == DRAIN_W'(MAX_ITEMS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_fire && !held[1].valid) begin
                    n_state = ST_LOAD;
                    n_count = '0;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_drain <= n_drain;
        end
    end

endmodule
`default_nettype wire

/* verif/sort_and_remove_duplicates_tb.sv */
// testbench for the sort-and-dedup block: random batches checked against a sorting predictor
`default_nettype none
module sort_and_remove_duplicates_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY      = 64;
    localparam int MAX_GAP       = 14;
    localparam int ITEM_TARGET   = 430;
    localparam int LONG_HOLD     = 300;
    // time for the chain to settle after the closing item, plus margin
    localparam int SETTLE_CYCLES = CAPACITY + 30;
    // cycles with no item moving on either channel before we give up
    localparam int STALL_LIMIT   = 3000;
    localparam int MAX_PRINTS    = 30;

    typedef logic signed [sru_pkg::VALUE_W-1:0] t_value;

    // one distinct value as the block should emit it
    typedef struct packed {
        t_value value;
        logic   final_flag;
        logic   overflow;
    } t_unique;

    // how the values of a batch are drawn
    typedef enum int {
        VALS_FULL,    // anywhere in the 32-bit range
        VALS_NARROW,  // a handful of small values, lots of duplicates
        VALS_EDGES    // around the signed extremes and zero
    } t_value_mix;

    logic i_clk;
    logic i_rst_n;

    sru_in_if  in_if ();
    sru_out_if out_if ();

    sort_and_remove_duplicates #(
        .MAX_ITEMS (CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predictor state: the batch being loaded and the results still owed
    t_value  batch_values[$];
    bit      batch_dropped;
    t_unique pending_uniques[$];

    // knobs shared between the stimulus and the result sink
    bit steady_flow;
    int sink_hold_cycles;

    int items_sent;
    int batches_closed;
    int overflow_batches;
    int results_checked;
    int error_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (error_count < MAX_PRINTS) begin
            $display("%0t mismatch: %s (expected 0x%08h, got 0x%08h)", $realtime, what,
                     want, got);
        end
        error_count++;
    endtask

    // keep an accepted item; on the closing item, sort the kept values and queue
    // one result per distinct value
    task automatic predict_item(input t_value v, input logic last);
        t_value sorted[$];
        t_value held;
        int     j;
        if (batch_values.size() < CAPACITY) begin
            batch_values.push_back(v);
        end else begin
            // store full: the item is lost, even a closing one
            batch_dropped = 1'b1;
        end
        if (last) begin
            sorted = batch_values;
            for (int i = 1; i < sorted.size(); i++) begin
                held = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > held) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = held;
            end
            foreach (sorted[i]) begin
                if (i == 0 || sorted[i] != sorted[i-1]) begin
                    // first copy of the largest value is the final result
                    pending_uniques.push_back('{value: sorted[i],
                        final_flag: (sorted[i] == sorted[sorted.size()-1]),
                        overflow: batch_dropped});
                end
            end
            batches_closed++;
            if (batch_dropped) begin
                overflow_batches++;
            end
            batch_values.delete();
            batch_dropped = 1'b0;
        end
    endtask

    function automatic t_value pick_value(input t_value_mix mix);
        case (mix)
            VALS_NARROW: begin
                return t_value'($urandom_range(0, 16)) - 8;
            end
            VALS_EDGES: begin
                case ($urandom_range(0, 6))
                    0: return 32'sh8000_0000;
                    1: return 32'sh8000_0001;
                    2: return -1;
                    3: return 0;
                    4: return 1;
                    5: return 32'sh7FFF_FFFE;
                    default: return 32'sh7FFF_FFFF;
                endcase
            end
            default: begin
                return t_value'($urandom);
            end
        endcase
    endfunction

    // offer one item after a random gap and hold it until the block takes it;
    // valid stays high when the next item follows with no gap
    task automatic send_item(input t_value v, input logic last);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.value     <= v;
        in_if.batch_end <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_item(v, last);
        items_sent++;
    endtask

    task automatic send_batch(input int count, input t_value_mix mix);
        for (int i = 0; i < count; i++) begin
            send_item(pick_value(mix), i == count - 1);
        end
    endtask

    // sender goes quiet until every owed result has come out
    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (pending_uniques.size() != 0) @(posedge i_clk);
    endtask

    // extremes of the value range, duplicates, single-item batches
    task automatic test_directed();
        send_item(32'sh8000_0000, 1'b1);
        send_item(32'sh7FFF_FFFF, 1'b1);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b1);
        // whole batch one value: a single result, final
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(5, 1'b1);
        // largest value first and repeated at the close
        send_item(9, 1'b0);
        send_item(-9, 1'b0);
        send_item(9, 1'b1);
    endtask

    // a batch that exactly fills the store, then two that spill over
    task automatic test_capacity();
        send_batch(CAPACITY, VALS_NARROW);
        // closing item is dropped and must not show up among the results
        for (int i = 0; i < CAPACITY; i++) begin
            send_item(pick_value(VALS_NARROW), 1'b0);
        end
        send_item(32'sh7FFF_FFFF, 1'b1);
        for (int i = 0; i < CAPACITY; i++) begin
            send_item(pick_value(VALS_FULL), 1'b0);
        end
        for (int i = 0; i < 5; i++) begin
            send_item(pick_value(VALS_EDGES), 1'b0);
        end
        send_item(32'sh8000_0000, 1'b1);
    endtask

    // result sink sits out a long stretch while the next batch is already offered
    task automatic test_backpressure();
        sink_hold_cycles = LONG_HOLD;
        send_batch(24, VALS_FULL);
        send_batch(6, VALS_NARROW);
    endtask

    task automatic test_drain_pause();
        send_batch(5, VALS_EDGES);
        wait_for_results();
        send_batch(5, VALS_FULL);
    endtask

    // both sides at full rate
    task automatic test_steady_stream();
        steady_flow = 1'b1;
        for (int b = 0; b < 4; b++) begin
            send_batch(8, t_value_mix'(b % 3));
        end
        wait_for_results();
        steady_flow = 1'b0;
    endtask

    // mostly short batches, a few around the store size
    task automatic test_random_batches();
        int         pick;
        int         count;
        t_value_mix mix;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                count = $urandom_range(CAPACITY - 4, CAPACITY + 8);
            end else if (pick < 4) begin
                count = 1;
            end else begin
                count = $urandom_range(2, 16);
            end
            mix = t_value_mix'($urandom_range(0, 2));
            send_batch(count, mix);
        end
    endtask

    // result sink: random stall before each result, plus the long hold on request
    initial begin : result_sink
        int stall;
        out_if.ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge i_clk);
                sink_hold_cycles = 0;
            end
            stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            // leave early when a hold is requested and nothing was taken
            while (!out_if.valid && sink_hold_cycles == 0) @(posedge i_clk);
        end
    end

    // compare every accepted result with the oldest one owed
    always @(posedge i_clk) begin : result_check
        t_unique owed;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_checked++;
            if (pending_uniques.size() == 0) begin
                report_mismatch("result with nothing owed", '0, out_if.unique_value);
            end else begin
                owed = pending_uniques.pop_front();
                if (out_if.unique_value !== owed.value) begin
                    report_mismatch("unique_value", owed.value, out_if.unique_value);
                end
                if (out_if.final_result !== owed.final_flag) begin
                    report_mismatch("final_result", 32'(owed.final_flag),
                                    32'(out_if.final_result));
                end
                if (out_if.overflow !== owed.overflow) begin
                    report_mismatch("overflow", 32'(owed.overflow), 32'(out_if.overflow));
                end
            end
        end
    end

    // watchdog: nothing moving on either channel for too long ends the run
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t timeout: no item moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("sort_and_remove_duplicates_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.value      = '0;
        in_if.batch_end  = 1'b0;
        steady_flow      = 1'b0;
        sink_hold_cycles = 0;
        batch_dropped    = 1'b0;
        items_sent       = 0;
        batches_closed   = 0;
        overflow_batches = 0;
        results_checked  = 0;
        error_count      = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_capacity();
        test_backpressure();
        test_drain_pause();
        test_steady_stream();
        test_random_batches();

        // everything owed must arrive, then nothing more may follow
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_uniques.size() != 0) begin
            report_mismatch("results never arrived", 32'(pending_uniques.size()), '0);
        end

        $display("covered %0d items in %0d batches, %0d of them past capacity",
                 items_sent, batches_closed, overflow_batches);
        $display("checked %0d distinct-value results, %0d mismatches",
                 results_checked, error_count);
        if (error_count == 0) begin
            $display("sort_and_remove_duplicates_tb: PASS");
        end else begin
            $display("sort_and_remove_duplicates_tb: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
